>>> hdl/bwkt_pkg.sv
// ----------------------------------------------------------------------------
// bwkt_pkg
// Shared types and constants for the best/worst k-entry tracker.
// ----------------------------------------------------------------------------
package bwkt_pkg;

  // Fixed field widths
  localparam int FUNC_BITS = 2;
  localparam int ID_BITS   = 16;
  localparam int RANK_BITS = 7;
  localparam int KEEP_BITS = 8;

  // Operation codes carried in the input tuser
  localparam logic [FUNC_BITS-1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_INSERT = 2'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_READ   = 2'd2;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_PROBE,
    ST_WALK,
    ST_PUT,
    ST_DONE,
    ST_RD_B,
    ST_RD_W,
    ST_RD_OUT
  } state_t;

endpackage

>>> hdl/bwkt_ram.sv
// ----------------------------------------------------------------------------
// bwkt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bwkt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // read port, data held when no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/bwkt_cmp.sv
// ----------------------------------------------------------------------------
// bwkt_cmp
// Shared order compare: tells whether a stored entry stays ahead of a new one.
// ----------------------------------------------------------------------------
module bwkt_cmp #(
  parameter int ERROR_BITS = 48
) (
  input  logic [ERROR_BITS-1:0] entry_err,
  input  logic [ERROR_BITS-1:0] new_err,
  input  logic                  descending,
  output logic                  precede
);

  logic entry_le;
  logic entry_ge;

  // two magnitude compares, one per direction
  assign entry_le = (entry_err <= new_err);
  assign entry_ge = (entry_err >= new_err);

  // ties keep the stored entry ahead of the new one
  assign precede = descending ? entry_ge : entry_le;

endmodule

>>> hdl/best_worst_k_tracker.sv
// ----------------------------------------------------------------------------
// best_worst_k_tracker
// Keeps the keep_count lowest (ascending) and highest (descending) error
// entries, with clear, insert and rank-read operations.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  in_     | slave     | tvalid/tready     | tuser: func; tdata: index, error, rank
//  out_    | master    | tvalid/tready     | tuser: valid flags; tdata: best, worst
//  cfg_    | write     | cfg_we            | cfg_wdata: keep_count
//
//  Clear completes in the idle state; a read steps through RD_B, RD_W and RD_OUT.
//  Insert walks each list once through the shared compare and the list RAM,
//  one entry per cycle. in_tready is high only while the sequencer is idle.
//  A result waits in the output register; a read stalls only at its end.
//  Reset (rst_n low, synchronous) empties both lists; RAM contents are kept.
// ----------------------------------------------------------------------------
module best_worst_k_tracker #(
  parameter int MAX_KEEP   = 128,
  parameter int ERROR_BITS = 48
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  // input: [15:0] item_index, [16+:ERROR_BITS] error_value, next 7 bits rank
  input  logic [((bwkt_pkg::ID_BITS + ERROR_BITS + bwkt_pkg::RANK_BITS + 7) / 8) * 8 - 1:0]
                                                          in_tdata,
  // input tuser: [1:0] func
  input  logic [bwkt_pkg::FUNC_BITS-1:0]                  in_tuser,
  input  logic                                            in_tvalid,
  output logic                                            in_tready,
  // output: best_index, best_error, worst_index, worst_error from bit 0 up
  output logic [((2 * bwkt_pkg::ID_BITS + 2 * ERROR_BITS + 7) / 8) * 8 - 1:0]
                                                          out_tdata,
  // output tuser: [0] best_valid, [1] worst_valid
  output logic [1:0]                                      out_tuser,
  output logic                                            out_tvalid,
  input  logic                                            out_tready,
  input  logic                                            cfg_we,
  input  logic [bwkt_pkg::KEEP_BITS-1:0]                  cfg_wdata
);

  localparam int IDB    = bwkt_pkg::ID_BITS;
  localparam int RB     = bwkt_pkg::RANK_BITS;
  localparam int KB     = bwkt_pkg::KEEP_BITS;
  localparam int ENT_W  = ERROR_BITS + IDB;
  localparam int DEPTH  = 2 * MAX_KEEP;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(MAX_KEEP + 1);
  localparam int OUT_W  = ((2 * IDB + 2 * ERROR_BITS + 7) / 8) * 8;

  // input fields
  logic [IDB-1:0]        in_id;
  logic [ERROR_BITS-1:0] in_err;
  logic [RB-1:0]         in_rank;

  assign in_id   = in_tdata[IDB-1:0];
  assign in_err  = in_tdata[IDB +: ERROR_BITS];
  assign in_rank = in_tdata[IDB + ERROR_BITS +: RB];

  // registers
  bwkt_pkg::state_t      state_r, state_nxt;
  logic [CW-1:0]         fill_r, fill_nxt;
  logic [CW-1:0]         slot_r, slot_nxt;
  logic [CW-1:0]         start_r, start_nxt;
  logic [CW-1:0]         newsize_r, newsize_nxt;
  logic                  list_r, list_nxt;
  logic [KB-1:0]         keep_r;
  logic [IDB-1:0]        id_r, id_nxt;
  logic [ERROR_BITS-1:0] err_r, err_nxt;
  logic [RB-1:0]         rank_r, rank_nxt;
  logic                  rd_ok_r, rd_ok_nxt;
  logic [ENT_W-1:0]      hold_r, hold_nxt;
  logic [OUT_W-1:0]      out_data_r, out_data_nxt;
  logic [1:0]            out_user_r, out_user_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // RAM port signals
  logic                  ram_we;
  logic                  ram_re;
  logic [CW-1:0]         w_idx;
  logic [CW-1:0]         r_idx;
  logic                  r_list;
  logic                  w_new;
  logic [AW-1:0]         ram_waddr;
  logic [AW-1:0]         ram_raddr;
  logic [ENT_W-1:0]      ram_wdata;
  logic [ENT_W-1:0]      ram_rdata;

  // helpers
  logic [CW-1:0]         eff_keep;
  logic [CW:0]           fill_p1;
  logic [CW-1:0]         newsize_c;
  logic [CW-1:0]         start_c;
  logic [CW-1:0]         slot_m1;
  logic [CW-1:0]         slot_m2;
  logic [CW-1:0]         rank_idx;
  logic [ENT_W-1:0]      new_ent;
  logic                  precede;

  function automatic logic [AW-1:0] addr_of(input logic sel, input logic [CW-1:0] idx);
    addr_of = sel ? (AW'(MAX_KEEP) + AW'(idx)) : AW'(idx);
  endfunction

  // retained length and first target slot of an insert
  assign eff_keep  = (keep_r == '0) ? CW'(1) :
                     ((keep_r > KB'(MAX_KEEP)) ? CW'(MAX_KEEP) : CW'(keep_r));
  assign fill_p1   = {1'b0, fill_r} + (CW + 1)'(1);
  assign newsize_c = (fill_p1 < {1'b0, eff_keep}) ? CW'(fill_p1) : eff_keep;
  assign start_c   = (fill_r < (newsize_c - CW'(1))) ? fill_r : (newsize_c - CW'(1));

  assign slot_m1   = slot_r - CW'(1);
  assign slot_m2   = slot_r - CW'(2);
  assign rank_idx  = CW'(rank_r);
  assign new_ent   = {id_r, err_r};

  // shared compare unit
  bwkt_cmp #(
    .ERROR_BITS (ERROR_BITS)
  ) u_cmp (
    .entry_err  (ram_rdata[ERROR_BITS-1:0]),
    .new_err    (err_r),
    .descending (list_r),
    .precede    (precede)
  );

  // list storage: best list in the lower half, worst list in the upper half
  assign ram_waddr = addr_of(list_r, w_idx);
  assign ram_raddr = addr_of(r_list, r_idx);
  assign ram_wdata = w_new ? new_ent : ram_rdata;

  bwkt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bwkt_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          case (in_tuser)
            bwkt_pkg::FUNC_INSERT: state_nxt = bwkt_pkg::ST_START;
            bwkt_pkg::FUNC_READ:   state_nxt = bwkt_pkg::ST_RD_B;
            default:               state_nxt = bwkt_pkg::ST_IDLE;
          endcase
        end
      end
      bwkt_pkg::ST_START: begin
        if (slot_r < fill_r) begin
          state_nxt = bwkt_pkg::ST_PROBE;
        end else if (slot_r == '0) begin
          state_nxt = bwkt_pkg::ST_DONE;
        end else begin
          state_nxt = bwkt_pkg::ST_WALK;
        end
      end
      bwkt_pkg::ST_PROBE: begin
        if (precede || (slot_r == '0)) begin
          state_nxt = bwkt_pkg::ST_DONE;
        end else begin
          state_nxt = bwkt_pkg::ST_WALK;
        end
      end
      bwkt_pkg::ST_WALK: begin
        if (precede) begin
          state_nxt = bwkt_pkg::ST_DONE;
        end else if (slot_m1 == '0) begin
          state_nxt = bwkt_pkg::ST_PUT;
        end
      end
      bwkt_pkg::ST_PUT:  state_nxt = bwkt_pkg::ST_DONE;
      bwkt_pkg::ST_DONE: begin
        state_nxt = list_r ? bwkt_pkg::ST_IDLE : bwkt_pkg::ST_START;
      end
      bwkt_pkg::ST_RD_B: state_nxt = bwkt_pkg::ST_RD_W;
      bwkt_pkg::ST_RD_W: state_nxt = bwkt_pkg::ST_RD_OUT;
      bwkt_pkg::ST_RD_OUT: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = bwkt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bwkt_pkg::ST_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    fill_nxt      = fill_r;
    slot_nxt      = slot_r;
    start_nxt     = start_r;
    newsize_nxt   = newsize_r;
    list_nxt      = list_r;
    id_nxt        = id_r;
    err_nxt       = err_r;
    rank_nxt      = rank_r;
    rd_ok_nxt     = rd_ok_r;
    hold_nxt      = hold_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_valid_nxt = out_valid_r && !out_tready;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    w_idx         = slot_r;
    w_new         = 1'b1;
    r_idx         = slot_r;
    r_list        = list_r;

    case (state_r)
      bwkt_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          id_nxt   = in_id;
          err_nxt  = in_err;
          rank_nxt = in_rank;
          case (in_tuser)
            bwkt_pkg::FUNC_CLEAR: fill_nxt = '0;
            bwkt_pkg::FUNC_INSERT: begin
              newsize_nxt = newsize_c;
              start_nxt   = start_c;
              slot_nxt    = start_c;
              list_nxt    = 1'b0;
            end
            bwkt_pkg::FUNC_READ: begin
              rd_ok_nxt = ({1'b0, in_rank} < KB'(fill_r));
            end
            default: ;
          endcase
        end
      end
      // insert start: a full list checks whether the new item falls past the end, else write or walk
      bwkt_pkg::ST_START: begin
        if (slot_r < fill_r) begin
          ram_re = 1'b1;
        end else if (slot_r == '0) begin
          ram_we = 1'b1;
        end else begin
          ram_re = 1'b1;
          r_idx  = slot_m1;
        end
      end
      bwkt_pkg::ST_PROBE: begin
        if (!precede) begin
          if (slot_r == '0) begin
            ram_we = 1'b1;
          end else begin
            ram_re = 1'b1;
            r_idx  = slot_m1;
          end
        end
      end
      // shift one entry down per cycle, prefetching the next one
      bwkt_pkg::ST_WALK: begin
        ram_we = 1'b1;
        if (!precede) begin
          w_new    = 1'b0;
          slot_nxt = slot_m1;
          if (slot_m1 != '0) begin
            ram_re = 1'b1;
            r_idx  = slot_m2;
          end
        end
      end
      bwkt_pkg::ST_PUT: ram_we = 1'b1;
      bwkt_pkg::ST_DONE: begin
        if (!list_r) begin
          list_nxt = 1'b1;
          slot_nxt = start_r;
        end else begin
          fill_nxt = newsize_r;
        end
      end
      // rank read: best entry, then worst entry
      bwkt_pkg::ST_RD_B: begin
        ram_re = rd_ok_r;
        r_idx  = rank_idx;
        r_list = 1'b0;
      end
      bwkt_pkg::ST_RD_W: begin
        hold_nxt = ram_rdata;
        ram_re   = rd_ok_r;
        r_idx    = rank_idx;
        r_list   = 1'b1;
      end
      bwkt_pkg::ST_RD_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = {rd_ok_r, rd_ok_r};
          out_data_nxt  = '0;
          if (rd_ok_r) begin
            out_data_nxt[IDB-1:0]                     = hold_r[ERROR_BITS +: IDB];
            out_data_nxt[IDB +: ERROR_BITS]           = hold_r[ERROR_BITS-1:0];
            out_data_nxt[IDB + ERROR_BITS +: IDB]     = ram_rdata[ERROR_BITS +: IDB];
            out_data_nxt[2 * IDB + ERROR_BITS +: ERROR_BITS] = ram_rdata[ERROR_BITS-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bwkt_pkg::ST_IDLE;
      fill_r      <= '0;
      keep_r      <= KB'(2);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        keep_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    slot_r     <= slot_nxt;
    start_r    <= start_nxt;
    newsize_r  <= newsize_nxt;
    list_r     <= list_nxt;
    id_r       <= id_nxt;
    err_r      <= err_nxt;
    rank_r     <= rank_nxt;
    rd_ok_r    <= rd_ok_nxt;
    hold_r     <= hold_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign in_tready  = (state_r == bwkt_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef ASSERT_OFF
  // list length never exceeds the storage
  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(MAX_KEEP))
    else $error("fill count beyond list depth");

  // no write lands past the retained length
  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (slot_r < newsize_r))
    else $error("list write past retained length");

  // a result is only loaded at the end of a rank read
  a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == bwkt_pkg::ST_RD_OUT))
    else $error("result loaded outside rank read");

  // best and worst valid flags agree, as both lists hold the same number of entries
  a_flags_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_user_r[0] == out_user_r[1]))
    else $error("best and worst valid flags differ");

  // an empty rank reads as zeros
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_user_r[0]) |-> (out_data_r == '0))
    else $error("invalid result carries data");
`endif

endmodule
